@@ rtl/core/kfs_pkg.sv @@
// shared types, constants and codes for the keyframe spline interpolator
`timescale 1ns / 1ps
package kfs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_KEYS  = 64;
	localparam int KEY_AW    = $clog2(MAX_KEYS);
	localparam int CNT_W     = KEY_AW + 1;
	localparam int TIME_W    = 32;
	localparam int POS_W     = 32;
	localparam int VEC_W     = 3 * POS_W;
	// divider: signed numerator and denominator, magnitudes one bit narrower
	localparam int NUM_W     = TIME_W + FRAC_BITS + 1;
	localparam int DEN_W     = TIME_W + 1;
	localparam int NUM_MAG_W = NUM_W - 1;
	localparam int DEN_MAG_W = DEN_W - 1;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_EMPTY = 2'd1;
	localparam logic [1:0] ERR_LAST  = 2'd2;
	localparam logic [1:0] ERR_SPAN  = 2'd3;

	typedef struct packed {
		logic                     kind;
		logic [KEY_AW-1:0]        key_slot;
		logic [TIME_W-1:0]        key_time;
		logic signed [POS_W-1:0]  key_x;
		logic signed [POS_W-1:0]  key_y;
		logic signed [POS_W-1:0]  key_z;
		logic [TIME_W-1:0]        query_time;
	} kfs_in_t;

	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic [1:0]               error_code;
	} kfs_res_t;

	typedef struct packed {
		logic                     en;
		logic [KEY_AW-1:0]        addr;
		logic [TIME_W-1:0]        ktime;
		logic [VEC_W-1:0]         kpos;
	} kfs_wr_t;

	typedef struct packed {
		logic                     go;
		logic signed [NUM_W-1:0]  num;
		logic signed [DEN_W-1:0]  den;
	} kfs_div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [NUM_W-1:0]  quo;
		logic [DEN_MAG_W-1:0]     rem;
	} kfs_div_rsp_t;

endpackage

@@ rtl/core/kfs_store.sv @@
// keyframe table: time memory and position memory, one write and one read port
`timescale 1ns / 1ps
module kfs_store import kfs_pkg::*; (
	input  logic                 clk,
	input  kfs_wr_t              wr,
	input  logic [KEY_AW-1:0]    rd_addr,
	output logic [TIME_W-1:0]    rd_time,
	output logic [VEC_W-1:0]     rd_pos
);

	logic [TIME_W-1:0] time_mem [MAX_KEYS];
	logic [VEC_W-1:0]  pos_mem  [MAX_KEYS];

	// write on load, registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			time_mem[wr.addr] <= wr.ktime;
			pos_mem[wr.addr]  <= wr.kpos;
		end
		rd_time <= time_mem[rd_addr];
		rd_pos  <= pos_mem[rd_addr];
	end

endmodule

@@ rtl/core/kfs_div.sv @@
// bit-serial signed divider, quotient truncated toward zero
`timescale 1ns / 1ps
module kfs_div import kfs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  kfs_div_req_t  req,
	output kfs_div_rsp_t  rsp
);

	localparam int CW = $clog2(NUM_MAG_W + 1);

	logic                  run_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [NUM_MAG_W-1:0]  nmag_q;
	logic [DEN_MAG_W-1:0]  dmag_q;
	logic [DEN_MAG_W:0]    rem_q;
	logic [NUM_MAG_W-1:0]  quo_q;
	logic                  neg_q;

	logic signed [NUM_W-1:0] num_abs;
	logic signed [DEN_W-1:0] den_abs;
	logic [DEN_MAG_W:0]      trial;
	logic                    ge;
	logic [DEN_MAG_W:0]      rem_nx;

	// magnitudes and one restoring step
	always_comb begin
		num_abs = req.num[NUM_W-1] ? -req.num : req.num;
		den_abs = req.den[DEN_W-1] ? -req.den : req.den;
		trial   = {rem_q[DEN_MAG_W-1:0], nmag_q[NUM_MAG_W-1]};
		ge      = trial >= {1'b0, dmag_q};
		rem_nx  = ge ? trial - {1'b0, dmag_q} : trial;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NUM_MAG_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.go) begin
			nmag_q <= num_abs[NUM_MAG_W-1:0];
			dmag_q <= den_abs[DEN_MAG_W-1:0];
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
		end else if (run_q) begin
			rem_q  <= rem_nx;
			quo_q  <= {quo_q[NUM_MAG_W-2:0], ge};
			nmag_q <= {nmag_q[NUM_MAG_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign rsp.rem  = rem_q[DEN_MAG_W-1:0];

endmodule

@@ rtl/core/keyframe_spline_interpolator.sv @@
// sequence: a load writes the table on its transfer; a query runs from its transfer to the
// result strobe through a time wrap division, a linear key search (one table read per key
// examined), a fetch of four keys, three more divisions, then 20 sequenced multiplies on
// one shared multiplier; an empty table answers straight from idle with ERR_EMPTY
// throughput: one query at a time, set by the bit-serial divider and key search
// reset clears the sequencer and key_count; table entries hold nothing until loaded
// the result strobe lasts one cycle and the receiver cannot stall
`timescale 1ns / 1ps
module keyframe_spline_interpolator import kfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kfs_in_t           item,
	output logic              done,
	output kfs_res_t          result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE, S_LAST_RD, S_LAST_USE, S_MOD_WT, S_SRCH_RD, S_SRCH_USE,
		S_KEY_SET, S_KEY_RD, S_KEY_USE, S_U_GO, S_U_WT, S_RA_GO, S_RA_WT,
		S_RB_GO, S_RB_WT, S_MUL, S_TAKE, S_HERM
	} state_t;

	localparam int MA_W = 38;
	localparam int MB_W = 34;
	localparam int PR_W = MA_W + MB_W;
	localparam int U_W  = FRAC_BITS + 1;
	localparam int H_W  = FRAC_BITS + 3;
	localparam int R_W  = 30;
	localparam int ACC_W = 64;

	localparam logic signed [NUM_W-1:0] ONE_Q    = NUM_W'(1) <<< FRAC_BITS;
	localparam logic signed [NUM_W-1:0] RATIO_LIM = NUM_W'(1) <<< 28;
	localparam logic signed [PR_W-1:0]  TAN_LIM  = PR_W'(1) <<< 36;
	localparam logic signed [ACC_W-1:0] OUT_MAX  = ACC_W'(64'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] OUT_MIN  = -(ACC_W'(64'sh8000_0000));

	state_t state_q;

	logic [CNT_W-1:0]        key_count_q;
	logic [KEY_AW-1:0]       nm1_q;
	logic [TIME_W-1:0]       qt_q;
	logic [TIME_W-1:0]       tq_q;
	logic [KEY_AW-1:0]       addr_q;
	logic [KEY_AW-1:0]       sidx_q;
	logic [KEY_AW-1:0]       nx_q;
	logic [1:0]              kidx_q;
	logic [TIME_W-1:0]       t_q [4];
	logic [VEC_W-1:0]        p_q [4];
	logic signed [DEN_W-1:0] span_q;
	logic [U_W-1:0]          u_q, u2_q, u3_q;
	logic signed [R_W-1:0]   ra_q, rb_q;
	logic signed [H_W-1:0]   h00_q, h01_q, h10_q, h11_q;
	logic [2:0]              op_q;
	logic [1:0]              c_q;
	logic signed [MA_W-1:0]  ma_q, mb_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PR_W-1:0]  prod_q;
	logic signed [POS_W-1:0] pos_q [2];
	logic                    done_q;
	kfs_res_t                res_q;

	kfs_wr_t                 wr;
	logic [TIME_W-1:0]       rd_time;
	logic [VEC_W-1:0]        rd_pos;
	kfs_div_req_t            dreq;
	kfs_div_rsp_t            drsp;

	logic                    accept;
	logic [CNT_W-1:0]        n_eff;
	logic [KEY_AW-1:0]       i0, i1, i3, kaddr;
	logic signed [DEN_W-1:0] span_nx, den_a, den_b;
	logic signed [NUM_W-1:0] span_num;
	logic signed [POS_W:0]   d20, d31;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [PR_W-1:0]  prod_sh;
	logic signed [ACC_W-1:0] acc_fin, acc_sh;
	logic signed [POS_W-1:0] p0c, p1c, p2c, p3c, out_c;
	logic signed [H_W-1:0]   u_s, u2_s, u3_s;

	// table instance and divider
	kfs_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (addr_q),
		.rd_time (rd_time),
		.rd_pos  (rd_pos)
	);

	kfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// handshakes
	assign busy      = state_q != S_IDLE;
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign done      = done_q;
	assign result    = res_q;

	// load path writes the table on transfer
	assign wr.en    = accept && (item.kind == KIND_LOAD);
	assign wr.addr  = item.key_slot;
	assign wr.ktime = item.key_time;
	assign wr.kpos  = {item.key_z, item.key_y, item.key_x};

	// neighbor indices with circular wrap
	always_comb begin
		n_eff = (key_count_q > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : key_count_q;
		i1 = (nx_q == '0) ? nm1_q : nx_q - 1'b1;
		i0 = (i1 == '0) ? nm1_q : i1 - 1'b1;
		i3 = (nx_q == nm1_q) ? '0 : nx_q + 1'b1;
		case (kidx_q)
			2'd0:    kaddr = i0;
			2'd1:    kaddr = i1;
			2'd2:    kaddr = nx_q;
			default: kaddr = i3;
		endcase
	end

	// spans and tangent denominators
	always_comb begin
		span_nx  = $signed({1'b0, t_q[2]}) - $signed({1'b0, t_q[1]});
		den_a    = $signed({1'b0, t_q[2]}) - $signed({1'b0, t_q[0]});
		den_b    = $signed({1'b0, t_q[3]}) - $signed({1'b0, t_q[1]});
		span_num = NUM_W'(span_q) <<< FRAC_BITS;
	end

	// divider requests
	always_comb begin
		dreq.go  = 1'b0;
		dreq.num = '0;
		dreq.den = '0;
		case (state_q)
			S_LAST_USE: begin
				dreq.go  = rd_time != '0;
				dreq.num = NUM_W'({1'b0, qt_q});
				dreq.den = DEN_W'({1'b0, rd_time});
			end
			S_U_GO: begin
				dreq.go  = span_nx != '0;
				dreq.num = NUM_W'($signed({1'b0, tq_q}) - $signed({1'b0, t_q[1]}))
					<<< FRAC_BITS;
				dreq.den = span_nx;
			end
			S_RA_GO: begin
				dreq.go  = den_a != '0;
				dreq.num = span_num;
				dreq.den = den_a;
			end
			S_RB_GO: begin
				dreq.go  = den_b != '0;
				dreq.num = span_num;
				dreq.den = den_b;
			end
			default: ;
		endcase
	end

	// multiplier operand select
	always_comb begin
		p0c = p_q[0][c_q*POS_W +: POS_W];
		p1c = p_q[1][c_q*POS_W +: POS_W];
		p2c = p_q[2][c_q*POS_W +: POS_W];
		p3c = p_q[3][c_q*POS_W +: POS_W];
		d20 = (POS_W+1)'(p2c) - (POS_W+1)'(p0c);
		d31 = (POS_W+1)'(p3c) - (POS_W+1)'(p1c);
		case (op_q)
			3'd0:    begin mul_a = MA_W'({1'b0, u_q});  mul_b = MB_W'({1'b0, u_q}); end
			3'd1:    begin mul_a = MA_W'({1'b0, u2_q}); mul_b = MB_W'({1'b0, u_q}); end
			3'd2:    begin mul_a = MA_W'(d20);          mul_b = MB_W'(ra_q);         end
			3'd3:    begin mul_a = MA_W'(d31);          mul_b = MB_W'(rb_q);         end
			3'd4:    begin mul_a = MA_W'(p1c);          mul_b = MB_W'(h00_q);        end
			3'd5:    begin mul_a = MA_W'(p2c);          mul_b = MB_W'(h01_q);        end
			3'd6:    begin mul_a = ma_q;                mul_b = MB_W'(h10_q);        end
			default: begin mul_a = mb_q;                mul_b = MB_W'(h11_q);        end
		endcase
	end

	// shared multiplier, registered product
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// product post-processing
	always_comb begin
		prod_sh = prod_q >>> FRAC_BITS;
		acc_fin = acc_q + ACC_W'(prod_q);
		acc_sh  = acc_fin >>> FRAC_BITS;
		if (acc_sh > OUT_MAX) begin
			out_c = POS_W'(OUT_MAX);
		end else if (acc_sh < OUT_MIN) begin
			out_c = POS_W'(OUT_MIN);
		end else begin
			out_c = POS_W'(acc_sh);
		end
		u_s  = H_W'({1'b0, u_q});
		u2_s = H_W'({1'b0, u2_q});
		u3_s = H_W'({1'b0, u3_q});
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				key_count_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && item.kind == KIND_QUERY) begin
						qt_q <= item.query_time;
						if (n_eff == '0) begin
							res_q  <= '{pos_x: '0, pos_y: '0, pos_z: '0, error_code: ERR_EMPTY};
							done_q <= 1'b1;
						end else begin
							nm1_q   <= KEY_AW'(n_eff - 1'b1);
							addr_q  <= KEY_AW'(n_eff - 1'b1);
							state_q <= S_LAST_RD;
						end
					end
				end
				S_LAST_RD: state_q <= S_LAST_USE;
				S_LAST_USE: begin
					if (rd_time == '0) begin
						res_q   <= '{pos_x: '0, pos_y: '0, pos_z: '0, error_code: ERR_LAST};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MOD_WT;
					end
				end
				S_MOD_WT: begin
					if (drsp.done) begin
						tq_q    <= drsp.rem;
						sidx_q  <= '0;
						addr_q  <= '0;
						state_q <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: state_q <= S_SRCH_USE;
				S_SRCH_USE: begin
					if (rd_time > tq_q || sidx_q == nm1_q) begin
						nx_q    <= sidx_q;
						kidx_q  <= '0;
						state_q <= S_KEY_SET;
					end else begin
						sidx_q  <= sidx_q + 1'b1;
						addr_q  <= sidx_q + 1'b1;
						state_q <= S_SRCH_RD;
					end
				end
				S_KEY_SET: begin
					addr_q  <= kaddr;
					state_q <= S_KEY_RD;
				end
				S_KEY_RD: state_q <= S_KEY_USE;
				S_KEY_USE: begin
					t_q[kidx_q] <= rd_time;
					p_q[kidx_q] <= rd_pos;
					kidx_q      <= kidx_q + 1'b1;
					state_q     <= (kidx_q == 2'd3) ? S_U_GO : S_KEY_SET;
				end
				S_U_GO: begin
					span_q <= span_nx;
					if (span_nx == '0) begin
						res_q   <= '{pos_x: '0, pos_y: '0, pos_z: '0, error_code: ERR_SPAN};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_U_WT;
					end
				end
				S_U_WT: begin
					if (drsp.done) begin
						if (drsp.quo < 0) begin
							u_q <= '0;
						end else if (drsp.quo > ONE_Q) begin
							u_q <= U_W'(ONE_Q);
						end else begin
							u_q <= U_W'(drsp.quo);
						end
						state_q <= S_RA_GO;
					end
				end
				S_RA_GO: begin
					ra_q    <= '0;
					state_q <= (den_a == '0) ? S_RB_GO : S_RA_WT;
				end
				S_RA_WT: begin
					if (drsp.done) begin
						if (drsp.quo > RATIO_LIM) begin
							ra_q <= R_W'(RATIO_LIM);
						end else if (drsp.quo < -RATIO_LIM) begin
							ra_q <= R_W'(-RATIO_LIM);
						end else begin
							ra_q <= R_W'(drsp.quo);
						end
						state_q <= S_RB_GO;
					end
				end
				S_RB_GO: begin
					rb_q <= '0;
					op_q <= 3'd0;
					c_q  <= 2'd0;
					state_q <= (den_b == '0) ? S_MUL : S_RB_WT;
				end
				S_RB_WT: begin
					if (drsp.done) begin
						if (drsp.quo > RATIO_LIM) begin
							rb_q <= R_W'(RATIO_LIM);
						end else if (drsp.quo < -RATIO_LIM) begin
							rb_q <= R_W'(-RATIO_LIM);
						end else begin
							rb_q <= R_W'(drsp.quo);
						end
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_TAKE;
				S_HERM: begin
					h00_q   <= (u3_s <<< 1) - (u2_s + (u2_s <<< 1)) + H_W'(ONE_Q);
					h01_q   <= (u2_s + (u2_s <<< 1)) - (u3_s <<< 1);
					h10_q   <= u3_s - (u2_s <<< 1) + u_s;
					h11_q   <= u3_s - u2_s;
					op_q    <= 3'd2;
					state_q <= S_MUL;
				end
				S_TAKE: begin
					case (op_q)
						3'd0: begin
							u2_q    <= U_W'(prod_sh);
							op_q    <= op_q + 1'b1;
							state_q <= S_MUL;
						end
						3'd1: begin
							u3_q    <= U_W'(prod_sh);
							state_q <= S_HERM;
						end
						3'd2, 3'd3: begin
							op_q    <= op_q + 1'b1;
							state_q <= S_MUL;
							if (prod_sh > TAN_LIM) begin
								if (op_q == 3'd2) ma_q <= MA_W'(TAN_LIM);
								else mb_q <= MA_W'(TAN_LIM);
							end else if (prod_sh < -TAN_LIM) begin
								if (op_q == 3'd2) ma_q <= MA_W'(-TAN_LIM);
								else mb_q <= MA_W'(-TAN_LIM);
							end else begin
								if (op_q == 3'd2) ma_q <= MA_W'(prod_sh);
								else mb_q <= MA_W'(prod_sh);
							end
						end
						3'd4: begin
							acc_q   <= ACC_W'(prod_q);
							op_q    <= op_q + 1'b1;
							state_q <= S_MUL;
						end
						3'd5, 3'd6: begin
							acc_q   <= acc_fin;
							op_q    <= op_q + 1'b1;
							state_q <= S_MUL;
						end
						default: begin
							op_q <= 3'd2;
							c_q  <= c_q + 1'b1;
							if (c_q == 2'd2) begin
								res_q   <= '{pos_x: pos_q[0], pos_y: pos_q[1], pos_z: out_c,
									error_code: ERR_OK};
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								pos_q[c_q[0]] <= out_c;
								state_q       <= S_MUL;
							end
						end
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
